[hdl/ygbd_pkg.sv]
// Package for the grid box decoder: payload and job types, register map,
// sequencer states and the sigmoid table generator. No dependencies.
`default_nettype none
package ygbd_pkg;

    localparam int SIG_DEPTH = 1024;
    localparam int SIG_AW    = $clog2(SIG_DEPTH);

    typedef logic [15:0] t_sig_rom [SIG_DEPTH];

    typedef struct packed {
        logic signed [15:0] logit;
        logic               last_of_cell;
        logic [7:0]         grid_x;
        logic [7:0]         grid_y;
        logic [2:0]         stride_shift;
        logic [9:0]         anchor_width;
        logic [9:0]         anchor_height;
    } t_in_item;

    typedef struct packed {
        logic [11:0] box_left;
        logic [11:0] box_top;
        logic [11:0] box_right;
        logic [11:0] box_bottom;
        logic [15:0] box_score;
        logic [7:0]  class_id;
    } t_out_item;

    typedef struct packed {
        logic [15:0] score_threshold;
        logic [15:0] inverse_scale;
        logic [11:0] pad_x;
        logic [11:0] pad_y;
        logic [11:0] clip_width;
        logic [11:0] clip_height;
        logic [7:0]  class_count;
    } t_cfg;

    // One finished cell, handed from the front end to the decode sequencer.
    typedef struct packed {
        logic signed [15:0] lg_x;
        logic signed [15:0] lg_y;
        logic signed [15:0] lg_w;
        logic signed [15:0] lg_h;
        logic signed [15:0] lg_obj;
        logic signed [15:0] lg_cls;
        logic [7:0]         class_id;
        logic [7:0]         grid_x;
        logic [7:0]         grid_y;
        logic [2:0]         stride_shift;
        logic [9:0]         anchor_width;
        logic [9:0]         anchor_height;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCORE,
        ST_SIZE_SQ,
        ST_SIZE_MUL,
        ST_EDGE,
        ST_OUT
    } t_back_state;

    localparam logic [2:0] REG_SCORE_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_INVERSE_SCALE   = 3'd1;
    localparam logic [2:0] REG_PAD_X           = 3'd2;
    localparam logic [2:0] REG_PAD_Y           = 3'd3;
    localparam logic [2:0] REG_CLIP_WIDTH      = 3'd4;
    localparam logic [2:0] REG_CLIP_HEIGHT     = 3'd5;
    localparam logic [2:0] REG_CLASS_COUNT     = 3'd6;

    localparam logic [8:0] HEADER_LEN = 9'd5;

    // Table address for a Q5.10 logit covering [-8, 8).
    function automatic logic [SIG_AW-1:0] sig_index(input logic signed [15:0] lg);
        logic signed [17:0] v;
        logic [17:0]        q;
        begin
            v = 18'(lg) + 18'sd8192;
            q = 18'(v >>> 4);
            if (v < 0) begin
                sig_index = '0;
            end else if (q > 18'(SIG_DEPTH - 1)) begin
                sig_index = SIG_AW'(SIG_DEPTH - 1);
            end else begin
                sig_index = q[SIG_AW-1:0];
            end
        end
    endfunction

    // Builds the Q0.16 sigmoid table at elaboration. exp(-|x|) comes from a
    // short Taylor series at |x|/256 followed by eight squarings.
    function automatic t_sig_rom build_sig_rom();
        t_sig_rom         tbl;
        longint           xq20;
        longint unsigned  a, u, t1, t2, t3, t4, e, den, num, rem, quo;
        int               k, b;
        begin
            for (int i = 0; i < SIG_DEPTH; i++) begin
                xq20 = longint'(((64'(2 * i + 1)) << 23) / SIG_DEPTH) - (longint'(8) << 20);
                a    = (xq20 < 0) ? longint'(-xq20) : longint'(xq20);
                u    = a << 3;
                t1   = u;
                t2   = ((t1 * u) >> 31) >> 1;
                t3   = ((t2 * u) >> 31) / 3;
                t4   = ((t3 * u) >> 31) >> 2;
                e    = 64'h8000_0000 - t1 + t2 - t3 + t4;
                for (k = 0; k < 8; k++) begin
                    e = (e * e) >> 31;
                end
                den = 64'h8000_0000 + e;
                num = ((xq20 >= 0) ? 64'h8000_0000 : e);
                num = (num << 16) + (den >> 1);
                rem = '0;
                quo = '0;
                for (b = 63; b >= 0; b--) begin
                    rem = (rem << 1) | ((num >> b) & 64'd1);
                    if (rem >= den) begin
                        rem = rem - den;
                        quo = quo | (64'd1 << b);
                    end
                end
                tbl[i] = (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
            end
            build_sig_rom = tbl;
        end
    endfunction

endpackage
`default_nettype wire

[hdl/ygbd_front.sv]
// Front end: counts the elements of a cell, keeps the box and objectness
// logits and the running class argmax, and emits one job per complete cell.
// Depends on ygbd_pkg.
`default_nettype none
module ygbd_front #(
    parameter int MAX_CLASSES = 80
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire ygbd_pkg::t_in_item i_item,
    input  wire logic [7:0]        i_class_count,
    output logic                   o_push,
    output ygbd_pkg::t_job         o_job
);

    localparam logic [8:0] MAX_CLS = 9'(MAX_CLASSES);

    logic [8:0]         r_count, n_count;
    logic signed [15:0] r_box [4];
    logic signed [15:0] r_obj;
    logic signed [15:0] r_best, n_best;
    logic [7:0]         r_best_idx, n_best_idx;
    logic [8:0]         limit;
    logic [8:0]         cls;
    logic               take;

    assign limit = ({1'b0, i_class_count} < MAX_CLS) ? {1'b0, i_class_count} : MAX_CLS;
    assign cls   = r_count - ygbd_pkg::HEADER_LEN;
    assign take  = (r_count >= ygbd_pkg::HEADER_LEN) &&
                   ((cls == 9'd0) || ((cls < limit) && (i_item.logit > r_best)));

    always_comb begin
        n_best     = take ? i_item.logit : r_best;
        n_best_idx = take ? cls[7:0] : r_best_idx;
        if (i_item.last_of_cell) begin
            n_count = '0;
        end else if (r_count != 9'd511) begin
            n_count = r_count + 9'd1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_best_idx <= '0;
        end else if (i_accept) begin
            r_count    <= n_count;
            r_best_idx <= n_best_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (r_count < 9'd4) begin
                r_box[r_count[1:0]] <= i_item.logit;
            end
            if (r_count == 9'd4) begin
                r_obj <= i_item.logit;
            end
            r_best <= n_best;
        end
    end

    assign o_push = i_accept && i_item.last_of_cell && (r_count >= ygbd_pkg::HEADER_LEN);

    always_comb begin
        o_job.lg_x          = r_box[0];
        o_job.lg_y          = r_box[1];
        o_job.lg_w          = r_box[2];
        o_job.lg_h          = r_box[3];
        o_job.lg_obj        = r_obj;
        o_job.lg_cls        = n_best;
        o_job.class_id      = n_best_idx;
        o_job.grid_x        = i_item.grid_x;
        o_job.grid_y        = i_item.grid_y;
        o_job.stride_shift  = i_item.stride_shift;
        o_job.anchor_width  = i_item.anchor_width;
        o_job.anchor_height = i_item.anchor_height;
    end

endmodule
`default_nettype wire

[hdl/ygbd_fifo.sv]
// Two-entry job queue between the front end and the decode sequencer.
// Depends on ygbd_pkg.
`default_nettype none
module ygbd_fifo (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire ygbd_pkg::t_job i_job,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_empty,
    output ygbd_pkg::t_job  o_job
);

    ygbd_pkg::t_job r_mem [2];
    logic           r_wptr, r_rptr;
    logic [1:0]     r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_fill <= r_fill + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule
`default_nettype wire

[hdl/ygbd_back.sv]
// Decode sequencer: six sigmoid lookups through one table port, score and
// threshold, center and size, then the box edges through one shared multiplier.
// Depends on ygbd_pkg.
`default_nettype none
module ygbd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ygbd_pkg::t_cfg i_cfg,
    input  wire logic          i_job_valid,
    input  wire ygbd_pkg::t_job i_job,
    output logic               o_pop,
    output logic               o_valid,
    output ygbd_pkg::t_out_item o_item,
    input  wire logic          i_stall
);

    localparam ygbd_pkg::t_sig_rom SIG_ROM = ygbd_pkg::build_sig_rom();

    ygbd_pkg::t_back_state r_state, n_state;

    logic [2:0]                 r_cnt;
    logic [15:0]                r_rom_q;
    logic [ygbd_pkg::SIG_AW-1:0] rom_addr;
    logic [15:0]                r_sig [6];
    logic [15:0]                r_score;
    logic signed [33:0]         r_cx, r_cy;
    logic [33:0]                r_sqw, r_sqh;
    logic [27:0]                r_w, r_h;
    logic signed [36:0]         r_v;
    logic signed [53:0]         r_prod;
    logic [11:0]                r_edge [4];
    logic                       r_ovalid;
    ygbd_pkg::t_out_item        r_oitem;

    logic                       below;
    logic                       out_free;
    logic                       out_load;
    logic signed [15:0]         look_logit;
    logic signed [25:0]         cx_base, cy_base;
    logic signed [36:0]         half_w, half_h, pad_xs, pad_ys, v_sel;
    logic [1:0]                 edge_idx;
    logic [11:0]                limit;
    logic [24:0]                p_hi;
    logic [11:0]                clamped;
    logic [31:0]                score_prod;

    // Lookup order: objectness, best class, x, y, w, h.
    always_comb begin
        case (r_cnt)
            3'd0:    look_logit = i_job.lg_obj;
            3'd1:    look_logit = i_job.lg_cls;
            3'd2:    look_logit = i_job.lg_x;
            3'd3:    look_logit = i_job.lg_y;
            3'd4:    look_logit = i_job.lg_w;
            default: look_logit = i_job.lg_h;
        endcase
    end
    assign rom_addr = ygbd_pkg::sig_index(look_logit);

    always_ff @(posedge i_clk) begin
        r_rom_q <= SIG_ROM[rom_addr];
    end

    assign below      = (r_score < i_cfg.score_threshold);
    assign out_free   = !r_ovalid || !i_stall;
    assign score_prod = 32'(r_sig[0]) * 32'(r_sig[1]);

    assign cx_base = $signed({9'd0, r_sig[2], 1'b0}) - 26'sd32768
                   + $signed({2'd0, i_job.grid_x, 16'd0});
    assign cy_base = $signed({9'd0, r_sig[3], 1'b0}) - 26'sd32768
                   + $signed({2'd0, i_job.grid_y, 16'd0});

    assign half_w = $signed({9'd0, r_w}) + 37'sd32768;
    assign half_h = $signed({9'd0, r_h}) + 37'sd32768;
    assign pad_xs = $signed({8'd0, i_cfg.pad_x, 17'd0});
    assign pad_ys = $signed({8'd0, i_cfg.pad_y, 17'd0});

    // Edge order: left, top, right, bottom.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    v_sel = 37'(r_cx <<< 1) - half_w - pad_xs;
            2'd1:    v_sel = 37'(r_cy <<< 1) - half_h - pad_ys;
            2'd2:    v_sel = 37'(r_cx <<< 1) + half_w - pad_xs;
            default: v_sel = 37'(r_cy <<< 1) + half_h - pad_ys;
        endcase
    end

    assign edge_idx = 2'(r_cnt - 3'd2);
    assign limit    = edge_idx[0] ? i_cfg.clip_height : i_cfg.clip_width;
    assign p_hi     = r_prod[53:29];

    // Negative products clip to zero; the rest truncate and clip to the limit.
    always_comb begin
        if (r_prod < 0) begin
            clamped = '0;
        end else if (p_hi > 25'(limit)) begin
            clamped = limit;
        end else begin
            clamped = p_hi[11:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ygbd_pkg::ST_IDLE:     if (i_job_valid) n_state = ygbd_pkg::ST_LOOK;
            ygbd_pkg::ST_LOOK:     if (r_cnt == 3'd6) n_state = ygbd_pkg::ST_SCORE;
            ygbd_pkg::ST_SCORE:    n_state = ygbd_pkg::ST_SIZE_SQ;
            ygbd_pkg::ST_SIZE_SQ:  n_state = below ? ygbd_pkg::ST_IDLE : ygbd_pkg::ST_SIZE_MUL;
            ygbd_pkg::ST_SIZE_MUL: n_state = ygbd_pkg::ST_EDGE;
            ygbd_pkg::ST_EDGE:     if (r_cnt == 3'd5) n_state = ygbd_pkg::ST_OUT;
            ygbd_pkg::ST_OUT:      if (out_free) n_state = ygbd_pkg::ST_IDLE;
            default:               n_state = ygbd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ygbd_pkg::ST_SIZE_SQ: o_pop = below;
            ygbd_pkg::ST_OUT: begin
                o_pop    = out_free;
                out_load = out_free;
            end
            default: begin
                o_pop    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ygbd_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 3'd1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ygbd_pkg::ST_LOOK && r_cnt != 3'd0) begin
            r_sig[r_cnt - 3'd1] <= r_rom_q;
        end
        if (r_state == ygbd_pkg::ST_SCORE) begin
            r_score <= score_prod[31:16];
        end
        if (r_state == ygbd_pkg::ST_SIZE_SQ) begin
            r_sqw <= 34'({r_sig[4], 1'b0}) * 34'({r_sig[4], 1'b0});
            r_sqh <= 34'({r_sig[5], 1'b0}) * 34'({r_sig[5], 1'b0});
            r_cx  <= 34'(cx_base) <<< i_job.stride_shift;
            r_cy  <= 34'(cy_base) <<< i_job.stride_shift;
        end
        if (r_state == ygbd_pkg::ST_SIZE_MUL) begin
            r_w <= 28'((44'(r_sqw) * 44'(i_job.anchor_width)) >> 16);
            r_h <= 28'((44'(r_sqh) * 44'(i_job.anchor_height)) >> 16);
        end
        if (r_state == ygbd_pkg::ST_EDGE) begin
            if (r_cnt < 3'd4) begin
                r_v <= v_sel;
            end
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_prod <= 54'(r_v) * $signed({38'd0, i_cfg.inverse_scale});
            end
            if (r_cnt >= 3'd2) begin
                r_edge[edge_idx] <= clamped;
            end
        end
        if (out_load) begin
            r_oitem.box_left   <= r_edge[0];
            r_oitem.box_top    <= r_edge[1];
            r_oitem.box_right  <= r_edge[2];
            r_oitem.box_bottom <= r_edge[3];
            r_oitem.box_score  <= r_score;
            r_oitem.class_id   <= i_job.class_id;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

endmodule
`default_nettype wire

[hdl/yolo_grid_box_decode_top.sv]
// Grid box decoder top: input logit stream, APB register file, front end,
// job queue and decode sequencer. Throughput: one logit per cycle while the queue has
// room; the sequencer holds a cell's job through the idle check, six table lookups on
// one port and the score, and drops it when its score is below the threshold; else it
// goes on through sizes, the edges on one multiplier and output load, plus output stalls.
// Synchronous active-low reset restores register defaults and empties the queue.
`default_nettype none
module yolo_grid_box_decode_top #(
    parameter int MAX_CLASSES = 80
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire ygbd_pkg::t_in_item   i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output ygbd_pkg::t_out_item       o_out_data,
    input  wire logic                 i_out_stall,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    ygbd_pkg::t_cfg r_cfg;
    ygbd_pkg::t_job front_job, head_job;
    logic           accept, push, pop, full, empty, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.score_threshold <= 16'd32768;
            r_cfg.inverse_scale   <= 16'd4096;
            r_cfg.pad_x           <= '0;
            r_cfg.pad_y           <= '0;
            r_cfg.clip_width      <= 12'd640;
            r_cfg.clip_height     <= 12'd640;
            r_cfg.class_count     <= 8'd80;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                ygbd_pkg::REG_SCORE_THRESHOLD: r_cfg.score_threshold <= pwdata[15:0];
                ygbd_pkg::REG_INVERSE_SCALE:   r_cfg.inverse_scale   <= pwdata[15:0];
                ygbd_pkg::REG_PAD_X:           r_cfg.pad_x           <= pwdata[11:0];
                ygbd_pkg::REG_PAD_Y:           r_cfg.pad_y           <= pwdata[11:0];
                ygbd_pkg::REG_CLIP_WIDTH:      r_cfg.clip_width      <= pwdata[11:0];
                ygbd_pkg::REG_CLIP_HEIGHT:     r_cfg.clip_height     <= pwdata[11:0];
                ygbd_pkg::REG_CLASS_COUNT:     r_cfg.class_count     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            ygbd_pkg::REG_SCORE_THRESHOLD: prdata = 32'(r_cfg.score_threshold);
            ygbd_pkg::REG_INVERSE_SCALE:   prdata = 32'(r_cfg.inverse_scale);
            ygbd_pkg::REG_PAD_X:           prdata = 32'(r_cfg.pad_x);
            ygbd_pkg::REG_PAD_Y:           prdata = 32'(r_cfg.pad_y);
            ygbd_pkg::REG_CLIP_WIDTH:      prdata = 32'(r_cfg.clip_width);
            ygbd_pkg::REG_CLIP_HEIGHT:     prdata = 32'(r_cfg.clip_height);
            ygbd_pkg::REG_CLASS_COUNT:     prdata = 32'(r_cfg.class_count);
            default:                       prdata = '0;
        endcase
    end

    // Stalling on a full queue keeps the front end from overrunning it.
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    ygbd_front #(
        .MAX_CLASSES(MAX_CLASSES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_data),
        .i_class_count (r_cfg.class_count),
        .o_push        (push),
        .o_job         (front_job)
    );

    ygbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (head_job)
    );

    ygbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (!empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .o_item      (o_out_data),
        .i_stall     (i_out_stall)
    );

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("job queue popped while empty");

    a_score_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_out_data.box_score >= r_cfg.score_threshold)
        else $error("box emitted below score threshold");

    a_clip_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_data.box_left <= r_cfg.clip_width &&
                                o_out_data.box_right <= r_cfg.clip_width))
        else $error("x edge beyond clip limit");

endmodule
`default_nettype wire
